/* rtl/mwt_pkg.sv */
`default_nettype none

package mwt_pkg;

  // one table entry: code key and learned word
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] word;
  } entry_t;

  // input item
  typedef struct packed {
    logic [31:0] code_key;
    logic [31:0] word_bytes;
  } in_t;

  // result item
  typedef struct packed {
    logic       status;
    logic [6:0] found_rank;
  } out_t;

  // result status codes
  localparam logic STATUS_NEW     = 1'b0;
  localparam logic STATUS_PRESENT = 1'b1;

  // sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_UPD  = 1'b1
  } state_e;

  // key must match fully; word bytes only where the code byte is in use
  function automatic logic entry_match(entry_t ent, logic [31:0] key, logic [31:0] word);
    logic ok;
    ok = (ent.key == key);
    for (int b = 0; b < 4; b++) begin
      if ((key[8*b +: 8] != 8'd0) && (ent.word[8*b +: 8] != word[8*b +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/mwt_cell.sv */
`default_nettype none

module mwt_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cmp_en_i,
  input  mwt_pkg::in_t     cmp_item_i,
  input  wire              shift_en_i,
  input  mwt_pkg::entry_t  prev_entry_i,
  output mwt_pkg::entry_t  entry_o,
  output logic             match_o
);

  mwt_pkg::entry_t entry_q;
  logic            match_q;

  // entry storage, loads from the neighbor closer to the front
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_en_i) begin
      entry_q <= prev_entry_i;
    end
  end

  // local compare against the incoming item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmp_en_i) begin
      match_q <= mwt_pkg::entry_match(entry_q, cmp_item_i.code_key, cmp_item_i.word_bytes);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/mru_word_table_insert.sv */
`default_nettype none

// Recency-ordered word table built as a chain of ENTRIES cells, rank 0 newest.
// In the accept cycle every cell compares its entry with the item in parallel
// and registers a hit bit; in the update state, once the held result is not
// stalled, the first hit is isolated, the cells from the front down to
// that rank shift one place toward the back and the hit entry (or the new item
// on a miss, which drops the oldest entry) loads the front cell. A new item is
// taken once the previous one has updated the table; the result register can
// hold one item while the next one is compared. On a hit the result gives
// status 1 and the rank before the move, on a miss status 0 and rank ENTRIES-1
// (low 7 bits). After reset every entry holds an all-zero key and word.

module mru_word_table_insert #(
  parameter int ENTRIES = 128
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  mwt_pkg::in_t   in_item_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output mwt_pkg::out_t  out_item_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mwt_pkg::state_e state_q, state_d;
  mwt_pkg::in_t    item_q;
  mwt_pkg::out_t   out_item_q;
  logic            out_valid_q;

  mwt_pkg::entry_t cell_entry [ENTRIES];
  mwt_pkg::entry_t cell_prev  [ENTRIES];
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] shift_mask;
  logic [ENTRIES-1:0] first_hit;
  logic [ENTRIES-1:0] shift_en;
  logic               any_hit;
  logic               accept;
  logic               upd;
  mwt_pkg::entry_t    hit_entry;
  mwt_pkg::entry_t    head_entry;
  logic [IDX_W-1:0]   hit_idx;

  assign accept = in_valid_i && !in_stall_o;

  // hold the item for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mwt_pkg::ST_IDLE: if (accept) state_d = mwt_pkg::ST_UPD;
      mwt_pkg::ST_UPD:  if (upd) state_d = mwt_pkg::ST_IDLE;
      default:          state_d = mwt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    upd        = 1'b0;
    case (state_q)
      mwt_pkg::ST_IDLE: in_stall_o = 1'b0;
      mwt_pkg::ST_UPD:  upd = !(out_valid_q && out_stall_i);
      default:          in_stall_o = 1'b1;
    endcase
  end

  // first hit: bits from rank 0 up to the lowest hit, all ones on a miss
  assign any_hit    = |hit_vec;
  assign shift_mask = hit_vec ^ (hit_vec - ENTRIES'(1));
  assign first_hit  = hit_vec & shift_mask;
  assign shift_en   = upd ? shift_mask : '0;

  // select the hit entry and encode its rank
  always_comb begin
    hit_entry = '0;
    hit_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_hit[i]) begin
        hit_entry = hit_entry | cell_entry[i];
        hit_idx   = hit_idx | IDX_W'(i);
      end
    end
  end

  assign head_entry = any_hit ? hit_entry
                              : mwt_pkg::entry_t'{key: item_q.code_key, word: item_q.word_bytes};

  // cell chain
  for (genvar r = 0; r < ENTRIES; r++) begin : g_cell
    if (r == 0) begin : g_head
      assign cell_prev[r] = head_entry;
    end else begin : g_body
      assign cell_prev[r] = cell_entry[r-1];
    end
    mwt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_en_i     (accept),
      .cmp_item_i   (in_item_i),
      .shift_en_i   (shift_en[r]),
      .prev_entry_i (cell_prev[r]),
      .entry_o      (cell_entry[r]),
      .match_o      (hit_vec[r])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_item_q.status     <= any_hit ? mwt_pkg::STATUS_PRESENT : mwt_pkg::STATUS_NEW;
      out_item_q.found_rank <= any_hit ? 7'(hit_idx) : 7'(ENTRIES - 1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // an accepted item always moves to the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == mwt_pkg::ST_UPD))
    else $error("accepted item did not reach update");

  // at most one cell is picked as the first hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwt_pkg::ST_UPD) |-> $onehot0(first_hit))
    else $error("more than one first hit");

  // an insert reports the oldest rank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && !any_hit) |=> (out_item_q.found_rank == 7'(ENTRIES - 1)))
    else $error("insert rank wrong");

  // an update never overwrites a result that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sim/mru_word_table_insert_tb.sv */
module mru_word_table_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 128;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int POOL_DEPTH    = 200;
  localparam int MAX_SHOWN     = 10;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  mwt_pkg::in_t  in_item_i   = '0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  mwt_pkg::out_t out_item_o;

  // predicted table contents, rank 0 newest
  mwt_pkg::entry_t mru_cells [TABLE_DEPTH];
  // expected results in order, and recently sent items for reuse
  mwt_pkg::out_t   result_q [$];
  mwt_pkg::in_t    recent_q [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit quiet          = 1'b0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mru_word_table_insert #(
    .ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // search newest to oldest, move the hit (or the new item) to the front
  function automatic mwt_pkg::out_t lookup_and_promote(mwt_pkg::in_t item);
    logic [31:0]     care;
    mwt_pkg::entry_t moved;
    mwt_pkg::out_t   res;
    int              hit_rank;
    care     = '0;
    hit_rank = -1;
    for (int b = 0; b < 4; b++) begin
      if (item.code_key[8*b +: 8] != 8'h00) care[8*b +: 8] = 8'hFF;
    end
    for (int r = 0; r < TABLE_DEPTH && hit_rank < 0; r++) begin
      if (mru_cells[r].key == item.code_key &&
          ((mru_cells[r].word ^ item.word_bytes) & care) == 32'h0) hit_rank = r;
    end
    if (hit_rank >= 0) begin
      // promoted entry keeps its stored word, unused bytes too
      moved      = mru_cells[hit_rank];
      res.status = mwt_pkg::STATUS_PRESENT;
    end else begin
      hit_rank   = TABLE_DEPTH - 1;
      moved.key  = item.code_key;
      moved.word = item.word_bytes;
      res.status = mwt_pkg::STATUS_NEW;
    end
    res.found_rank = 7'(hit_rank);
    for (int r = hit_rank; r > 0; r--) mru_cells[r] = mru_cells[r-1];
    mru_cells[0] = moved;
    return res;
  endfunction

  // reuse of recent items in 45 of 100 picks so that hits land at many ranks
  function automatic mwt_pkg::in_t make_random_item();
    mwt_pkg::in_t item;
    int           pick;
    int           b;
    pick = $urandom_range(0, 99);
    if (pick < 45 && recent_q.size() != 0) begin
      item = recent_q[$urandom_range(0, recent_q.size() - 1)];
      // unused positions take any word byte
      for (b = 0; b < 4; b++) begin
        if (item.code_key[8*b +: 8] == 8'h00) item.word_bytes[8*b +: 8] = 8'($urandom);
      end
      // occasional near miss
      if ($urandom_range(0, 6) == 0) begin
        b = $urandom_range(0, 3);
        item.word_bytes[8*b +: 8] ^= 8'($urandom_range(1, 255));
      end
    end else if (pick < 75) begin
      item.code_key   = $urandom;
      item.word_bytes = $urandom;
      for (b = 0; b < 4; b++) begin
        if ($urandom_range(0, 3) == 0) item.code_key[8*b +: 8] = 8'h00;
      end
    end else if (pick < 85) begin
      // narrow alphabet to force collisions
      for (b = 0; b < 4; b++) begin
        case ($urandom_range(0, 2))
          0: item.code_key[8*b +: 8] = 8'h00;
          1: item.code_key[8*b +: 8] = 8'h01;
          default: item.code_key[8*b +: 8] = 8'hFF;
        endcase
        item.word_bytes[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end else begin
      item.code_key   = $urandom;
      item.word_bytes = $urandom;
    end
    recent_q.push_back(item);
    if (recent_q.size() > POOL_DEPTH) void'(recent_q.pop_front());
    return item;
  endfunction

  // drive one item, wait for acceptance, record its expected result
  task automatic send_item(mwt_pkg::in_t item);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    result_q.push_back(lookup_and_promote(item));
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  // reset contents, full and empty bytes, unused word bytes, near misses
  task automatic test_directed();
    logic [63:0] seq [18];
    seq = '{
      64'h00000000_00000000, 64'h00000000_FFFFFFFF, 64'hFFFFFFFF_00000000,
      64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_00000000, 64'h000000FF_123456AB,
      64'h000000FF_FFFFFFAB, 64'h000000FF_000000AB, 64'h000000FF_000000AC,
      64'h00000000_5A5A5A5A, 64'hFF000000_AB000000, 64'hFF000000_AB123456,
      64'h00FF00FF_00110022, 64'h00FF00FF_11111122, 64'h80000000_80000000,
      64'h00000001_00000001, 64'h7FFFFFFF_7FFFFFFF, 64'hFFFFFFFF_FFFFFFFF
    };
    foreach (seq[i]) send_item(mwt_pkg::in_t'(seq[i]));
  endtask

  // fill the table with distinct keys, then replay them: each hits the oldest rank
  task automatic test_deep_ranks();
    mwt_pkg::in_t filled [TABLE_DEPTH];
    foreach (filled[i]) begin
      filled[i].code_key   = {8'hC3, 8'h5A, 8'(i + 1), 8'h77};
      filled[i].word_bytes = $urandom;
      send_item(filled[i]);
    end
    foreach (filled[i]) begin
      send_item(filled[i]);
      recent_q.push_back(filled[i]);
      if (recent_q.size() > POOL_DEPTH) void'(recent_q.pop_front());
    end
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_item(make_random_item());
  endtask

  // back to back items, no sender gaps and no receiver stalls
  task automatic test_no_idle(int count);
    quiet = 1'b1;
    repeat (count) send_item(make_random_item());
    quiet = 1'b0;
  endtask

  // sender holds off until every outstanding result is back
  task automatic test_drain_pause(int rounds, int count);
    repeat (rounds) begin
      repeat (count) send_item(make_random_item());
      in_valid_i <= 1'b0;
      wait_drained();
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    mwt_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result: status %0d rank %0d",
                   out_item_o.status, out_item_o.found_rank);
      end else begin
        want = result_q.pop_front();
        if (out_item_o.status !== want.status || out_item_o.found_rank !== want.found_rank)
        begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("result mismatch: expected status %0d rank %0d, got status %0d rank %0d",
                     want.status, want.found_rank, out_item_o.status, out_item_o.found_rank);
        end
      end
    end
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 10);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL mru_word_table_insert");
      $finish;
    end
  end

  // main sequence
  initial begin
    foreach (mru_cells[i]) mru_cells[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_deep_ranks();
    test_random_mix(700);
    test_no_idle(300);
    test_drain_pause(3, 50);
    test_random_mix(350);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS mru_word_table_insert");
    end else begin
      $display("FAIL mru_word_table_insert");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mwt_pkg.sv
rtl/mwt_cell.sv
rtl/mru_word_table_insert.sv
sim/mru_word_table_insert_tb.sv
